@@ sv/cis_pkg.sv @@
// ----------------------------------------------------------------------------
// Chamber imaging sequencer package
// Types, mode codes and register reset values shared by the sequencer files.
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_PRECON  = 3'd1;
  localparam logic [2:0] MODE_READY   = 3'd2;
  localparam logic [2:0] MODE_WARM    = 3'd3;
  localparam logic [2:0] MODE_FIRST   = 3'd4;
  localparam logic [2:0] MODE_RECUR   = 3'd5;
  localparam logic [2:0] MODE_UPLOAD  = 3'd6;

  localparam logic [2:0] REG_IDLE_TICKS      = 3'd0;
  localparam logic [2:0] REG_PRECON_TICKS    = 3'd1;
  localparam logic [2:0] REG_READY_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_FIRST_IMAGE     = 3'd3;
  localparam logic [2:0] REG_CAPTURE_START   = 3'd4;
  localparam logic [2:0] REG_CAPTURE_PERIOD  = 3'd5;
  localparam logic [2:0] REG_ROUND_LIMIT     = 3'd6;
  localparam logic [2:0] REG_UPLOAD_TICKS    = 3'd7;

  localparam logic [15:0] RST_IDLE_TICKS     = 16'd100;
  localparam logic [15:0] RST_PRECON_TICKS   = 16'd200;
  localparam logic [15:0] RST_READY_TIMEOUT  = 16'd400;
  localparam logic [15:0] RST_FIRST_IMAGE    = 16'd60;
  localparam logic [15:0] RST_CAPTURE_START  = 16'd200;
  localparam logic [15:0] RST_CAPTURE_PERIOD = 16'd400;
  localparam logic [7:0]  RST_ROUND_LIMIT    = 8'd10;
  localparam logic [15:0] RST_UPLOAD_TICKS   = 16'd200;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef struct packed {
    logic hand_in_chamber;
    logic warming_steady;
    logic hand_on_plate;
    logic cooling_steady;
    logic next_hand;
  } cis_in_t;

  typedef struct packed {
    logic system_on;
    logic cooler_on;
    logic heater_on;
    logic hand_heating_on;
    logic hand_cooling_on;
    logic image_capture_on;
    logic upload_on;
  } cis_enables_t;

  typedef struct packed {
    logic [2:0]   mode;
    logic         system_on;
    logic         cooler_on;
    logic         heater_on;
    logic         hand_heating_on;
    logic         hand_cooling_on;
    logic         image_capture_on;
    logic         upload_on;
  } cis_out_t;

  typedef struct packed {
    logic [15:0] idle_ticks;
    logic [15:0] precondition_ticks;
    logic [15:0] ready_timeout_ticks;
    logic [15:0] first_image_ticks;
    logic [15:0] capture_start_tick;
    logic [15:0] capture_period_ticks;
    logic [7:0]  image_round_limit;
    logic [15:0] upload_ticks;
  } cis_cfg_t;

  typedef struct packed {
    logic [2:0]   mode;
    logic [15:0]  timer;
    logic [7:0]   rounds;
    cis_enables_t en;
  } cis_state_t;

endpackage

@@ sv/cis_cfg.sv @@
// ----------------------------------------------------------------------------
// Chamber imaging sequencer configuration registers
// Holds the eight threshold registers written through the plain write port.
// ----------------------------------------------------------------------------
module cis_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata,
  output cis_pkg::cis_cfg_t cfg
);
  import cis_pkg::*;

  cis_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_ticks           <= RST_IDLE_TICKS;
      cfg_r.precondition_ticks   <= RST_PRECON_TICKS;
      cfg_r.ready_timeout_ticks  <= RST_READY_TIMEOUT;
      cfg_r.first_image_ticks    <= RST_FIRST_IMAGE;
      cfg_r.capture_start_tick   <= RST_CAPTURE_START;
      cfg_r.capture_period_ticks <= RST_CAPTURE_PERIOD;
      cfg_r.image_round_limit    <= RST_ROUND_LIMIT;
      cfg_r.upload_ticks         <= RST_UPLOAD_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_TICKS:     cfg_r.idle_ticks           <= cfg_wdata;
        REG_PRECON_TICKS:   cfg_r.precondition_ticks   <= cfg_wdata;
        REG_READY_TIMEOUT:  cfg_r.ready_timeout_ticks  <= cfg_wdata;
        REG_FIRST_IMAGE:    cfg_r.first_image_ticks    <= cfg_wdata;
        REG_CAPTURE_START:  cfg_r.capture_start_tick   <= cfg_wdata;
        REG_CAPTURE_PERIOD: cfg_r.capture_period_ticks <= cfg_wdata;
        REG_ROUND_LIMIT:    cfg_r.image_round_limit    <= cfg_wdata[7:0];
        REG_UPLOAD_TICKS:   cfg_r.upload_ticks         <= cfg_wdata;
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/cis_step.sv @@
// ----------------------------------------------------------------------------
// Chamber imaging sequencer step logic
// Computes the next mode, timer, round count and enables for one tick.
// ----------------------------------------------------------------------------
module cis_step (
  input  cis_pkg::cis_state_t cur,
  input  cis_pkg::cis_in_t    din,
  input  cis_pkg::cis_cfg_t   cfg,
  output cis_pkg::cis_state_t nxt
);
  import cis_pkg::*;

  logic [15:0] bumped;

  assign bumped = (cur.timer < TIMER_MAX) ? cur.timer + 16'd1 : cur.timer;

  always_comb begin
    nxt = cur;
    case (cur.mode)
      MODE_IDLE: begin
        nxt.en.system_on       = 1'b1;
        nxt.en.cooler_on       = 1'b0;
        nxt.en.heater_on       = 1'b0;
        nxt.en.hand_heating_on = 1'b0;
        nxt.timer              = bumped;
        if (bumped >= cfg.idle_ticks) begin
          nxt.mode  = MODE_PRECON;
          nxt.timer = 16'd0;
        end
      end
      MODE_PRECON: begin
        nxt.en.cooler_on = 1'b1;
        nxt.en.heater_on = 1'b1;
        nxt.timer        = bumped;
        if (bumped >= cfg.precondition_ticks) begin
          nxt.mode  = MODE_READY;
          nxt.timer = 16'd0;
        end
      end
      MODE_READY: begin
        nxt.en.cooler_on = 1'b1;
        nxt.en.heater_on = 1'b1;
        nxt.timer        = bumped;
        if (din.hand_in_chamber) begin
          nxt.mode  = MODE_WARM;
          nxt.timer = 16'd0;
        end else if (bumped >= cfg.ready_timeout_ticks) begin
          nxt.mode  = MODE_IDLE;
          nxt.timer = 16'd0;
        end
      end
      MODE_WARM: begin
        nxt.en.hand_heating_on = 1'b1;
        if (din.warming_steady && din.hand_on_plate) begin
          nxt.mode               = MODE_FIRST;
          nxt.en.hand_heating_on = 1'b0;
        end else if (!din.hand_in_chamber) begin
          nxt.mode               = MODE_READY;
          nxt.en.hand_heating_on = 1'b0;
        end
      end
      MODE_FIRST: begin
        nxt.en.image_capture_on = 1'b1;
        nxt.en.hand_cooling_on  = 1'b1;
        nxt.timer               = bumped;
        if (bumped >= cfg.first_image_ticks) begin
          nxt.mode                = MODE_RECUR;
          nxt.en.image_capture_on = 1'b0;
          nxt.timer               = 16'd0;
        end
        if (!din.hand_on_plate) begin
          nxt.mode                = MODE_READY;
          nxt.en.image_capture_on = 1'b0;
          nxt.timer               = 16'd0;
        end
      end
      MODE_RECUR: begin
        nxt.timer = bumped;
        if (bumped >= cfg.capture_start_tick && bumped < cfg.capture_period_ticks) begin
          nxt.en.image_capture_on = 1'b1;
        end else if (bumped >= cfg.capture_period_ticks) begin
          nxt.en.image_capture_on = 1'b0;
          nxt.timer               = 16'd0;
          nxt.rounds              = cur.rounds + 8'd1;
        end
        if (nxt.rounds == cfg.image_round_limit || din.cooling_steady) begin
          nxt.mode                = MODE_UPLOAD;
          nxt.en.image_capture_on = 1'b0;
          nxt.timer               = 16'd0;
          nxt.rounds              = 8'd0;
        end
        if (!din.hand_on_plate) begin
          nxt.mode                = MODE_READY;
          nxt.en.image_capture_on = 1'b0;
          nxt.timer               = 16'd0;
          nxt.rounds              = 8'd0;
        end
      end
      MODE_UPLOAD: begin
        nxt.en.upload_on       = 1'b1;
        nxt.en.cooler_on       = 1'b0;
        nxt.en.hand_cooling_on = 1'b0;
        nxt.timer              = bumped;
        if (din.next_hand) begin
          nxt.mode         = MODE_WARM;
          nxt.en.upload_on = 1'b0;
          nxt.timer        = 16'd0;
        end else if (bumped >= cfg.upload_ticks) begin
          nxt.mode         = MODE_READY;
          nxt.en.upload_on = 1'b0;
          nxt.timer        = 16'd0;
        end
      end
      default: begin
        nxt.mode  = MODE_IDLE;
        nxt.timer = 16'd0;
      end
    endcase
  end

endmodule

@@ sv/chamber_imaging_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Chamber imaging sequencer unit
// A result is registered and is valid in the cycle after its tick is transferred.
// Throughput: one tick per cycle, set by the combinational step logic and the
// one-entry result register; a stalled result holds off new ticks.
// Reset: synchronous active-low reset returns the sequencer to idle with the
// timer, round count and all enables cleared, and loads the register defaults.
// ----------------------------------------------------------------------------
module chamber_imaging_sequencer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cis_pkg::cis_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cis_pkg::cis_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import cis_pkg::*;

  cis_cfg_t   cfg;
  cis_state_t state_r;
  cis_state_t state_nxt;
  cis_out_t   out_data_r;
  logic       out_valid_r;
  logic       in_xfer;

  cis_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cis_step u_step (
    .cur (state_r),
    .din (in_data),
    .cfg (cfg),
    .nxt (state_nxt)
  );

  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode   <= MODE_IDLE;
      state_r.timer  <= 16'd0;
      state_r.rounds <= 8'd0;
      state_r.en     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r.mode             <= state_nxt.mode;
      out_data_r.system_on        <= state_nxt.en.system_on;
      out_data_r.cooler_on        <= state_nxt.en.cooler_on;
      out_data_r.heater_on        <= state_nxt.en.heater_on;
      out_data_r.hand_heating_on  <= state_nxt.en.hand_heating_on;
      out_data_r.hand_cooling_on  <= state_nxt.en.hand_cooling_on;
      out_data_r.image_capture_on <= state_nxt.en.image_capture_on;
      out_data_r.upload_on        <= state_nxt.en.upload_on;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/tb_chamber_imaging_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Chamber imaging sequencer unit testbench
// Drives one sensor tick per transfer and predicts the mode and the latched
// actuator enables of every tick with a behavioral copy of the sequencer.
// Directed walks cover zero thresholds, lowered thresholds, hand removal
// priority and round counter wrap; random phases sweep several threshold
// settings under random idling, a long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module tb_chamber_imaging_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cis_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 22;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cis_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  cis_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  cis_cfg_t   thr;
  cis_state_t st;
  cis_out_t   expected_status_q[$];
  cis_out_t   status_want;

  int sender_idle_pct = IDLE_PCT;
  int sink_stall_pct = IDLE_PCT;
  int hold_request = 0;
  int hold_left = 0;
  int fail_count = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int cycle_count = 0;
  logic [6:0] modes_seen = '0;

  chamber_imaging_sequencer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void bump_timer();
    if (st.timer != TIMER_MAX) st.timer++;
  endfunction

  function automatic cis_out_t advance_sequencer(cis_in_t t);
    cis_out_t r;
    case (st.mode)
      MODE_IDLE: begin
        st.en.system_on = 1'b1;
        st.en.cooler_on = 1'b0;
        st.en.heater_on = 1'b0;
        st.en.hand_heating_on = 1'b0;
        bump_timer();
        if (st.timer >= thr.idle_ticks) begin
          st.mode = MODE_PRECON;
          st.timer = '0;
        end
      end
      MODE_PRECON: begin
        st.en.cooler_on = 1'b1;
        st.en.heater_on = 1'b1;
        bump_timer();
        if (st.timer >= thr.precondition_ticks) begin
          st.mode = MODE_READY;
          st.timer = '0;
        end
      end
      MODE_READY: begin
        bump_timer();
        st.en.cooler_on = 1'b1;
        st.en.heater_on = 1'b1;
        if (t.hand_in_chamber) begin
          st.mode = MODE_WARM;
          st.timer = '0;
        end else if (st.timer >= thr.ready_timeout_ticks) begin
          st.mode = MODE_IDLE;
          st.timer = '0;
        end
      end
      MODE_WARM: begin
        st.en.hand_heating_on = 1'b1;
        if (t.warming_steady && t.hand_on_plate) begin
          st.mode = MODE_FIRST;
          st.en.hand_heating_on = 1'b0;
        end else if (!t.hand_in_chamber) begin
          st.mode = MODE_READY;
          st.en.hand_heating_on = 1'b0;
        end
      end
      MODE_FIRST: begin
        st.en.image_capture_on = 1'b1;
        st.en.hand_cooling_on = 1'b1;
        bump_timer();
        if (st.timer >= thr.first_image_ticks) begin
          st.mode = MODE_RECUR;
          st.en.image_capture_on = 1'b0;
          st.timer = '0;
        end
        if (!t.hand_on_plate) begin
          st.mode = MODE_READY;
          st.en.image_capture_on = 1'b0;
          st.timer = '0;
        end
      end
      MODE_RECUR: begin
        bump_timer();
        if (st.timer >= thr.capture_start_tick && st.timer < thr.capture_period_ticks) begin
          st.en.image_capture_on = 1'b1;
        end else if (st.timer >= thr.capture_period_ticks) begin
          st.en.image_capture_on = 1'b0;
          st.timer = '0;
          st.rounds++;
        end
        if (st.rounds == thr.image_round_limit || t.cooling_steady) begin
          st.mode = MODE_UPLOAD;
          st.en.image_capture_on = 1'b0;
          st.timer = '0;
          st.rounds = '0;
        end
        if (!t.hand_on_plate) begin
          st.mode = MODE_READY;
          st.en.image_capture_on = 1'b0;
          st.timer = '0;
          st.rounds = '0;
        end
      end
      MODE_UPLOAD: begin
        st.en.upload_on = 1'b1;
        st.en.cooler_on = 1'b0;
        st.en.hand_cooling_on = 1'b0;
        bump_timer();
        if (t.next_hand) begin
          st.mode = MODE_WARM;
          st.en.upload_on = 1'b0;
          st.timer = '0;
        end else if (st.timer >= thr.upload_ticks) begin
          st.mode = MODE_READY;
          st.en.upload_on = 1'b0;
          st.timer = '0;
        end
      end
      default: begin
        st.mode = MODE_IDLE;
        st.timer = '0;
      end
    endcase
    r.mode = st.mode;
    r.system_on = st.en.system_on;
    r.cooler_on = st.en.cooler_on;
    r.heater_on = st.en.heater_on;
    r.hand_heating_on = st.en.hand_heating_on;
    r.hand_cooling_on = st.en.hand_cooling_on;
    r.image_capture_on = st.en.image_capture_on;
    r.upload_on = st.en.upload_on;
    return r;
  endfunction

  function automatic cis_in_t mk_tick(logic hand, logic warm, logic plate, logic cool,
                                      logic nxt);
    cis_in_t t;
    t.hand_in_chamber = hand;
    t.warming_steady = warm;
    t.hand_on_plate = plate;
    t.cooling_steady = cool;
    t.next_hand = nxt;
    return t;
  endfunction

  // Mostly inputs that move the sequencer forward, with some pure noise.
  function automatic cis_in_t pick_tick();
    cis_in_t t;
    t = cis_in_t'(5'($urandom_range(31)));
    if ($urandom_range(99) >= 15) begin
      case (st.mode)
        MODE_READY: t.hand_in_chamber = ($urandom_range(99) < 25);
        MODE_WARM: begin
          t.hand_in_chamber = ($urandom_range(99) < 85);
          t.hand_on_plate = ($urandom_range(99) < 60);
        end
        MODE_FIRST: t.hand_on_plate = ($urandom_range(99) < 96);
        MODE_RECUR: begin
          t.hand_on_plate = ($urandom_range(99) < 98);
          t.cooling_steady = ($urandom_range(99) < 3);
        end
        MODE_UPLOAD: t.next_hand = ($urandom_range(99) < 8);
        default: ;
      endcase
    end
    return t;
  endfunction

  function automatic cis_cfg_t small_cfg();
    cis_cfg_t c;
    c.idle_ticks = 16'($urandom_range(12));
    c.precondition_ticks = 16'($urandom_range(12));
    c.ready_timeout_ticks = 16'($urandom_range(12));
    c.first_image_ticks = 16'($urandom_range(12));
    c.capture_period_ticks = 16'($urandom_range(15));
    c.capture_start_tick = 16'($urandom_range(c.capture_period_ticks));
    c.image_round_limit = 8'($urandom_range(1, 4));
    c.upload_ticks = 16'($urandom_range(12));
    return c;
  endfunction

  task automatic send_tick(cis_in_t t);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    expected_status_q.push_back(advance_sequencer(t));
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_status_q.size() != 0);
  endtask

  task automatic load_thresholds(cis_cfg_t c);
    for (int i = REG_IDLE_TICKS; i <= REG_UPLOAD_TICKS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      case (3'(i))
        REG_IDLE_TICKS:     cfg_wdata <= c.idle_ticks;
        REG_PRECON_TICKS:   cfg_wdata <= c.precondition_ticks;
        REG_READY_TIMEOUT:  cfg_wdata <= c.ready_timeout_ticks;
        REG_FIRST_IMAGE:    cfg_wdata <= c.first_image_ticks;
        REG_CAPTURE_START:  cfg_wdata <= c.capture_start_tick;
        REG_CAPTURE_PERIOD: cfg_wdata <= c.capture_period_ticks;
        REG_ROUND_LIMIT:    cfg_wdata <= {8'($urandom_range(255)), c.image_round_limit};
        default:            cfg_wdata <= c.upload_ticks;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    thr = c;
    settings_loaded++;
  endtask

  task automatic compare_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status_q.size() == 0) begin
        $error("Result transfer with no tick outstanding: mode %0d", out_data.mode);
        fail_count++;
      end else begin
        status_want = expected_status_q.pop_front();
        compare_field("mode", status_want.mode, out_data.mode);
        compare_field("system_on", status_want.system_on, out_data.system_on);
        compare_field("cooler_on", status_want.cooler_on, out_data.cooler_on);
        compare_field("heater_on", status_want.heater_on, out_data.heater_on);
        compare_field("hand_heating_on", status_want.hand_heating_on,
                      out_data.hand_heating_on);
        compare_field("hand_cooling_on", status_want.hand_cooling_on,
                      out_data.hand_cooling_on);
        compare_field("image_capture_on", status_want.image_capture_on,
                      out_data.image_capture_on);
        compare_field("upload_on", status_want.upload_on, out_data.upload_on);
        modes_seen[status_want.mode] = 1'b1;
        results_checked++;
      end
    end
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles.", cycle_count);
    $display("chamber_imaging_sequencer_unit verification failed");
    $finish;
  end

  // Register defaults are only visible before the first write.
  task automatic test_reset_defaults();
    repeat (320) send_tick(pick_tick());
  endtask

  task automatic test_directed_walk();
    cis_cfg_t c;
    c.idle_ticks = 16'd0;
    c.precondition_ticks = 16'd0;
    c.ready_timeout_ticks = 16'd3;
    c.first_image_ticks = 16'd2;
    c.capture_start_tick = 16'd1;
    c.capture_period_ticks = 16'd3;
    c.image_round_limit = 8'd2;
    c.upload_ticks = 16'hFFFF;
    drain_results();
    load_thresholds(c);
    while (st.mode != MODE_IDLE)
      send_tick(mk_tick(1'b0, 1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)), 1'b1));
    send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
    send_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
    repeat (7) send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Lower the upload and first image thresholds while the sequencer sits in upload.
    drain_results();
    c.upload_ticks = 16'd1;
    c.first_image_ticks = 16'd0;
    load_thresholds(c);
    send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
    send_tick(mk_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  // A zero period ends a round every tick; lowering the limit below the
  // count makes the counter wrap before imaging ends.
  task automatic test_round_wrap();
    cis_cfg_t c;
    c.idle_ticks = 16'd0;
    c.precondition_ticks = 16'd0;
    c.ready_timeout_ticks = 16'hFFFF;
    c.first_image_ticks = 16'd0;
    c.capture_start_tick = 16'd0;
    c.capture_period_ticks = 16'd0;
    c.image_round_limit = 8'd5;
    c.upload_ticks = 16'd0;
    drain_results();
    load_thresholds(c);
    while (!(st.mode == MODE_RECUR && st.rounds == 8'd3))
      send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
    drain_results();
    c.image_round_limit = 8'd2;
    load_thresholds(c);
    while (st.mode == MODE_RECUR)
      send_tick(mk_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1, 1'b0,
                        1'($urandom_range(1))));
  endtask

  task automatic test_backpressure();
    drain_results();
    load_thresholds(small_cfg());
    sender_idle_pct = 0;
    hold_request = 120;
    repeat (60) send_tick(pick_tick());
    sender_idle_pct = IDLE_PCT;
    drain_results();
    repeat (40) send_tick(pick_tick());
  endtask

  task automatic test_random_sweep();
    cis_cfg_t c;
    for (int p = 0; p < 6; p++) begin
      c = small_cfg();
      case (p)
        1: c = '0;
        2: begin
          c = '1;
          c.first_image_ticks = 16'd3;
        end
        3: c.capture_start_tick = c.capture_period_ticks + 16'($urandom_range(3));
        default: ;
      endcase
      sender_idle_pct = (p == 4) ? 0 : IDLE_PCT;
      sink_stall_pct = (p == 4) ? 0 : IDLE_PCT;
      drain_results();
      load_thresholds(c);
      repeat (105) send_tick(pick_tick());
    end
    sender_idle_pct = IDLE_PCT;
    sink_stall_pct = IDLE_PCT;
  endtask

  initial begin
    thr.idle_ticks = RST_IDLE_TICKS;
    thr.precondition_ticks = RST_PRECON_TICKS;
    thr.ready_timeout_ticks = RST_READY_TIMEOUT;
    thr.first_image_ticks = RST_FIRST_IMAGE;
    thr.capture_start_tick = RST_CAPTURE_START;
    thr.capture_period_ticks = RST_CAPTURE_PERIOD;
    thr.image_round_limit = RST_ROUND_LIMIT;
    thr.upload_ticks = RST_UPLOAD_TICKS;
    st = '0;
    st.mode = MODE_IDLE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_walk();
    test_round_wrap();
    test_backpressure();
    test_random_sweep();
    drain_results();
    repeat (4) @(posedge clk);
    $display("Sent %0d ticks and checked %0d results across %0d threshold settings.",
             ticks_sent, results_checked, settings_loaded);
    $display("Modes reached, one bit per mode code: %b", modes_seen);
    if (fail_count == 0 && expected_status_q.size() == 0)
      $display("chamber_imaging_sequencer_unit verification clean");
    else
      $display("chamber_imaging_sequencer_unit verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/cis_pkg.sv
sv/cis_cfg.sv
sv/cis_step.sv
sv/chamber_imaging_sequencer_unit.sv
tb/tb_chamber_imaging_sequencer_unit.sv
